### design/stable_priority_task_queue_assert.svh
// Assertion macros for the stable priority task queue.
// Used by the top level; no other dependencies.
`ifndef STABLE_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_TASK_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion, masked during reset
`define SPTQ_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Two conditions that must never hold together
`define SPTQ_ASSERT_EXCL(lbl, ck, rn, a, b, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !((a) && (b))) else $error(msg);
`else
`define SPTQ_ASSERT(lbl, ck, rn, prop, msg)
`define SPTQ_ASSERT_EXCL(lbl, ck, rn, a, b, msg)
`endif
`endif

### design/sptq_pkg.sv
// Shared types and constants for the stable priority task queue.
// No dependencies.
package sptq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = 5;

    // Command codes
    localparam logic [2:0] CMD_SUBMIT      = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE     = 3'd1;
    localparam logic [2:0] CMD_CANCEL_ID   = 3'd2;
    localparam logic [2:0] CMD_CANCEL_PAY  = 3'd3;
    localparam logic [2:0] CMD_CANCEL_ALL  = 3'd4;
    localparam logic [2:0] CMD_SHUTDOWN    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHUT     = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Register index
    localparam logic [1:0] REG_QUEUE_LIMIT = 2'd0;

    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] handler;
        logic [31:0] payload;
        logic [31:0] id;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

### design/sptq_if.sv
// Channel interfaces for task commands and results.
// Depends on nothing.
interface sptq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  prio;
    logic [31:0] handler;
    logic [31:0] payload;
    logic [31:0] key_id;
    modport source (output valid, cmd, prio, handler, payload, key_id, input ready);
    modport sink (input valid, cmd, prio, handler, payload, key_id, output ready);
endinterface

interface sptq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic [31:0] handler_out;
    logic [31:0] payload_out;
    logic [7:0]  prio_out;
    logic [4:0]  removed_count;
    logic [4:0]  pending;
    modport source (output valid, status, assigned_id, handler_out, payload_out, prio_out,
                    removed_count, pending, input ready);
    modport sink (input valid, status, assigned_id, handler_out, payload_out, prio_out,
                  removed_count, pending, output ready);
endinterface

### design/sptq_ctrl.sv
// Sequencing controller: accept, execute, deliver.
// Depends on sptq_pkg.
module sptq_ctrl
    import sptq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_EXEC;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_DONE;
                    out_valid_reg <= 1'b1;
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign ctl.load  = in_valid && in_ready_reg;
    assign ctl.exec  = (state_reg == S_EXEC);

endmodule

### design/sptq_datapath.sv
// Sorted cell array, counters and result registers.
// Depends on sptq_pkg.
module sptq_datapath
    import sptq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic [4:0]  queue_limit,
    input  logic [2:0]  cmd,
    input  logic [7:0]  prio,
    input  logic [31:0] handler,
    input  logic [31:0] payload,
    input  logic [31:0] key_id,
    output logic [2:0]  status,
    output logic [31:0] assigned_id,
    output logic [31:0] handler_out,
    output logic [31:0] payload_out,
    output logic [7:0]  prio_out,
    output logic [4:0]  removed_count,
    output logic [4:0]  pending
);

    // Latched command
    logic [2:0]  cmd_reg;
    logic [7:0]  prio_reg;
    logic [31:0] handler_reg;
    logic [31:0] payload_reg;
    logic [31:0] key_reg;

    entry_t             cell_reg [DEPTH];
    entry_t             cell_next [DEPTH];
    entry_t             ins_val [DEPTH];
    entry_t             rem_val [DEPTH];
    entry_t             new_ent;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [31:0]        id_reg, id_next;
    logic               halted_reg, halted_next;

    logic [2:0]         status_reg, status_next;
    logic [31:0]        aid_reg, aid_next;
    logic [31:0]        hout_reg, hout_next;
    logic [31:0]        pout_reg, pout_next;
    logic [7:0]         prout_reg, prout_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;

    logic [DEPTH-1:0]   occ, le, hit, first, after;
    logic [CNT_W-1:0]   eff_limit;
    logic               do_ins, do_rem;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= cmd;
            prio_reg    <= prio;
            handler_reg <= handler;
            payload_reg <= payload;
            key_reg     <= key_id;
        end
    end

    // Per-cell compares, each against its own cell
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = CNT_W'(i) < fill_reg;
            le[i]  = occ[i] && (cell_reg[i].prio <= prio_reg);
            if (cmd_reg == CMD_DEQUEUE)
                hit[i] = occ[i] && (i == 0);
            else if (cmd_reg == CMD_CANCEL_ID)
                hit[i] = occ[i] && (cell_reg[i].id == key_reg);
            else
                hit[i] = occ[i] && (cell_reg[i].payload == payload_reg);
        end
    end

    // First match and the cells at or above it
    assign first = hit & (~hit + DEPTH'(1));
    assign after = (first == '0) ? '0 : ~(first - DEPTH'(1));

    assign id_next = id_reg + 32'd1;
    assign new_ent = '{prio: prio_reg, handler: handler_reg, payload: payload_reg, id: id_next};

    // Insert shifts up, remove shifts down
    always_comb
    begin
        ins_val[0] = le[0] ? cell_reg[0] : new_ent;
        for (int i = 1; i < DEPTH; i++)
        begin
            if (le[i])
                ins_val[i] = cell_reg[i];
            else if (le[i-1])
                ins_val[i] = new_ent;
            else
                ins_val[i] = cell_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
            rem_val[i] = after[i] ? cell_reg[i+1] : cell_reg[i];
        rem_val[DEPTH-1] = cell_reg[DEPTH-1];
    end

    assign eff_limit = (queue_limit == '0 || queue_limit > CNT_W'(DEPTH))
                       ? CNT_W'(DEPTH) : queue_limit;

    // Command execution
    always_comb
    begin
        status_next  = ST_OK;
        aid_next     = '0;
        hout_next    = '0;
        pout_next    = '0;
        prout_next   = '0;
        removed_next = '0;
        fill_next    = fill_reg;
        halted_next  = halted_reg;
        do_ins       = 1'b0;
        do_rem       = 1'b0;
        unique case (cmd_reg)
            CMD_SUBMIT:
            begin
                if (halted_reg)
                    status_next = ST_SHUT;
                else if (fill_reg >= eff_limit)
                    status_next = ST_FULL;
                else
                begin
                    do_ins    = 1'b1;
                    aid_next  = id_next;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_DEQUEUE:
            begin
                if (fill_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    do_rem     = 1'b1;
                    aid_next   = cell_reg[0].id;
                    hout_next  = cell_reg[0].handler;
                    pout_next  = cell_reg[0].payload;
                    prout_next = cell_reg[0].prio;
                    fill_next  = fill_reg - CNT_W'(1);
                end
            end
            CMD_CANCEL_ID, CMD_CANCEL_PAY:
            begin
                if (halted_reg)
                    status_next = ST_SHUT;
                else if (hit == '0)
                    status_next = ST_NOTFOUND;
                else
                begin
                    do_rem    = 1'b1;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            CMD_CANCEL_ALL:
            begin
                if (halted_reg)
                    status_next = ST_SHUT;
                else
                begin
                    removed_next = fill_reg;
                    fill_next    = '0;
                end
            end
            CMD_SHUTDOWN:
            begin
                halted_next = 1'b1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_ins)
                cell_next[i] = ins_val[i];
            else if (do_rem)
                cell_next[i] = rem_val[i];
            else
                cell_next[i] = cell_reg[i];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            id_reg     <= 32'd1;
            halted_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            fill_reg   <= fill_next;
            halted_reg <= halted_next;
            if (do_ins)
                id_reg <= id_next;
        end
    end

    // Cells and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
                cell_reg[i] <= cell_next[i];
            status_reg  <= status_next;
            aid_reg     <= aid_next;
            hout_reg    <= hout_next;
            pout_reg    <= pout_next;
            prout_reg   <= prout_next;
            removed_reg <= removed_next;
        end
    end

    assign status        = status_reg;
    assign assigned_id   = aid_reg;
    assign handler_out   = hout_reg;
    assign payload_out   = pout_reg;
    assign prio_out      = prout_reg;
    assign removed_count = removed_reg;
    assign pending       = fill_reg;

endmodule

### design/stable_priority_task_queue.sv
// Top level of the stable priority task queue: APB register, controller, datapath.
// Depends on sptq_pkg, sptq_if, sptq_ctrl, sptq_datapath and the assertion header.
//
//  Channel  Dir  Handshake          Contents
//  in_ch    in   valid/ready        cmd, prio, handler, payload, key_id
//  out_ch   out  valid/ready        status, ids, handles, counts
//  apb      in   psel/penable       queue_limit at byte address 0
//
// A command is latched at its accepting edge; the next cycle executes it, the
// whole cell array shifting in parallel for insert or remove, and the result
// is valid from the edge after that. One command is in flight at a time; the
// next is accepted the cycle after the result is taken. A stalled result
// holds the block. Reset is immediate.
`include "stable_priority_task_queue_assert.svh"
module stable_priority_task_queue
    import sptq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sptq_in_if.sink     in_ch,
    sptq_out_if.source  out_ch
);

    logic [4:0] limit_reg;
    ctl_t       ctl;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (psel && penable && pwrite && paddr == REG_QUEUE_LIMIT)
            limit_reg <= pwdata[4:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_QUEUE_LIMIT) ? {27'd0, limit_reg} : 32'd0;

    sptq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl)
    );

    sptq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .queue_limit   (limit_reg),
        .cmd           (in_ch.cmd),
        .prio          (in_ch.prio),
        .handler       (in_ch.handler),
        .payload       (in_ch.payload),
        .key_id        (in_ch.key_id),
        .status        (out_ch.status),
        .assigned_id   (out_ch.assigned_id),
        .handler_out   (out_ch.handler_out),
        .payload_out   (out_ch.payload_out),
        .prio_out      (out_ch.prio_out),
        .removed_count (out_ch.removed_count),
        .pending       (out_ch.pending)
    );

    // Checks
    `SPTQ_ASSERT(a_lat, clk, rst_n, (in_ch.valid && in_ch.ready) |-> ##2 out_ch.valid, "late")
    `SPTQ_ASSERT_EXCL(a_one, clk, rst_n, in_ch.ready, out_ch.valid, "two transactions in flight")
    `SPTQ_ASSERT(a_fill, clk, rst_n, out_ch.valid |-> out_ch.pending <= 5'(DEPTH), "fill overflow")

endmodule
